// File: rtl/core/cdct_pkg.sv
`timescale 1ns / 1ps

package cdct_pkg;

  // Fixed widths of the narrow configuration registers.
  localparam int MarginBits  = 10;
  localparam int TickCfgBits = 8;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MIN_CHARGE   = 3'd0,
    CFG_DETECT_MARG  = 3'd1,
    CFG_RECOV_MARG   = 3'd2,
    CFG_OFFER_STEP   = 3'd3,
    CFG_PROBE_INTVL  = 3'd4,
    CFG_HOLDOFF      = 3'd5
  } cfg_idx_e;

  localparam logic [MarginBits-1:0]  DetectMargReset = 10'd25;
  localparam logic [MarginBits-1:0]  RecovMargReset  = 10'd25;
  localparam logic [MarginBits-1:0]  OfferStepReset  = 10'd50;
  localparam logic [TickCfgBits-1:0] ProbeIntvlReset = 8'd6;
  localparam logic [TickCfgBits-1:0] HoldoffReset    = 8'd6;
  localparam int                     MinChargeReset  = 600;

  // Configuration values of fixed width shared by the register file and the tracker.
  typedef struct packed {
    logic [MarginBits-1:0]  detect_margin;
    logic [MarginBits-1:0]  recovery_margin;
    logic [MarginBits-1:0]  offer_step;
    logic [TickCfgBits-1:0] probe_interval;
    logic [TickCfgBits-1:0] holdoff_ticks;
  } cfg_t;

endpackage

// File: rtl/core/cdct_cfg_regs.sv
`timescale 1ns / 1ps

module cdct_cfg_regs #(
  parameter int CURRENT_BITS = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [cdct_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [cdct_pkg::CfgDataBits-1:0]    cfg_data_i,
  output logic [CURRENT_BITS-1:0]             min_charge_o,
  output cdct_pkg::cfg_t                      cfg_o
);

  logic [CURRENT_BITS-1:0] min_charge_q;
  cdct_pkg::cfg_t          cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_charge_q          <= CURRENT_BITS'(cdct_pkg::MinChargeReset);
      cfg_q.detect_margin   <= cdct_pkg::DetectMargReset;
      cfg_q.recovery_margin <= cdct_pkg::RecovMargReset;
      cfg_q.offer_step      <= cdct_pkg::OfferStepReset;
      cfg_q.probe_interval  <= cdct_pkg::ProbeIntvlReset;
      cfg_q.holdoff_ticks   <= cdct_pkg::HoldoffReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cdct_pkg::CFG_MIN_CHARGE: begin
          min_charge_q <= cfg_data_i[CURRENT_BITS-1:0];
        end
        cdct_pkg::CFG_DETECT_MARG: begin
          cfg_q.detect_margin <= cfg_data_i[cdct_pkg::MarginBits-1:0];
        end
        cdct_pkg::CFG_RECOV_MARG: begin
          cfg_q.recovery_margin <= cfg_data_i[cdct_pkg::MarginBits-1:0];
        end
        cdct_pkg::CFG_OFFER_STEP: begin
          cfg_q.offer_step <= cfg_data_i[cdct_pkg::MarginBits-1:0];
        end
        cdct_pkg::CFG_PROBE_INTVL: begin
          cfg_q.probe_interval <= cfg_data_i[cdct_pkg::TickCfgBits-1:0];
        end
        cdct_pkg::CFG_HOLDOFF: begin
          cfg_q.holdoff_ticks <= cfg_data_i[cdct_pkg::TickCfgBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign min_charge_o = min_charge_q;
  assign cfg_o        = cfg_q;

endmodule

// File: rtl/core/cdct_tracker.sv
`timescale 1ns / 1ps

module cdct_tracker #(
  parameter int CURRENT_BITS    = 13,
  parameter int TICK_COUNT_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_en_i,
  input  logic [CURRENT_BITS-1:0] min_charge_i,
  input  cdct_pkg::cfg_t          cfg_i,
  input  logic [CURRENT_BITS-1:0] limit_current_i,
  input  logic [CURRENT_BITS-1:0] measured_now_i,
  input  logic [CURRENT_BITS-1:0] pilot_now_i,
  input  logic [CURRENT_BITS-1:0] offered_now_i,
  input  logic                    is_charging_i,
  input  logic                    is_demanding_i,
  output logic [CURRENT_BITS-1:0] granted_limit_o,
  output logic                    cap_applied_o
);

  localparam int CW = CURRENT_BITS;
  localparam int TC = TICK_COUNT_BITS;
  // Sums of a current and a margin need one bit over the wider operand.
  localparam int SW = ((CW > cdct_pkg::MarginBits) ? CW : cdct_pkg::MarginBits) + 1;
  localparam int TW = (TC > cdct_pkg::TickCfgBits) ? TC : cdct_pkg::TickCfgBits;
  localparam logic [TC-1:0] TickMax = '1;

  logic          cap_active_q, cap_active_d;
  logic [CW-1:0] cap_value_q, cap_value_d;
  logic [TC-1:0] probe_count_q, probe_count_d;
  logic [CW-1:0] probe_ref_q, probe_ref_d;
  logic [TC-1:0] holdoff_q, holdoff_d;
  logic          prev_chg_q, prev_chg_d;
  logic [CW-1:0] prev_offer_q, prev_offer_d;

  logic [TC-1:0] sat_probe, sat_holdoff;
  logic [TW-1:0] probe_ext, holdoff_ext;

  assign probe_ext   = TW'(cfg_i.probe_interval);
  assign holdoff_ext = TW'(cfg_i.holdoff_ticks);
  assign sat_probe   = (probe_ext > TW'(TickMax)) ? TickMax : probe_ext[TC-1:0];
  assign sat_holdoff = (holdoff_ext > TW'(TickMax)) ? TickMax : holdoff_ext[TC-1:0];

  always_comb begin
    logic          detect;
    logic          release_cap;
    logic [SW-1:0] meas_w, cap_plus, ref_plus, offer_plus, meas_plus;

    cap_active_d    = cap_active_q;
    cap_value_d     = cap_value_q;
    probe_count_d   = probe_count_q;
    probe_ref_d     = probe_ref_q;
    holdoff_d       = holdoff_q;
    prev_chg_d      = prev_chg_q;
    prev_offer_d    = prev_offer_q;
    granted_limit_o = limit_current_i;
    cap_applied_o   = 1'b0;
    detect          = 1'b0;
    release_cap     = 1'b0;
    meas_w          = SW'(measured_now_i);
    cap_plus        = '0;
    ref_plus        = '0;
    offer_plus      = SW'(prev_offer_q) + SW'(cfg_i.offer_step);
    meas_plus       = meas_w + SW'(cfg_i.detect_margin);

    if (!is_demanding_i || (limit_current_i == '0)) begin
      cap_active_d  = 1'b0;
      cap_value_d   = '0;
      probe_count_d = '0;
      probe_ref_d   = '0;
      holdoff_d     = '0;
      prev_chg_d    = 1'b0;
    end else begin
      if (is_charging_i != prev_chg_q) begin
        cap_active_d  = 1'b0;
        cap_value_d   = '0;
        probe_count_d = '0;
        probe_ref_d   = '0;
        holdoff_d     = '0;
      end
      prev_chg_d = is_charging_i;

      if (!is_charging_i) begin
        prev_offer_d = '0;
      end else begin
        // No holdoff on the first offer after a restart, when the last offer reads zero.
        if ((prev_offer_q != '0) && (SW'(offered_now_i) > offer_plus)) begin
          holdoff_d = sat_holdoff;
        end
        prev_offer_d = offered_now_i;

        if (holdoff_d != '0) begin
          holdoff_d = holdoff_d - TC'(1);
        end else begin
          detect = (pilot_now_i > min_charge_i) && (measured_now_i != '0) &&
                   (pilot_now_i != '0) && (meas_plus < SW'(pilot_now_i));
        end

        if (detect) begin
          if (!cap_active_d || (measured_now_i < cap_value_d)) begin
            cap_value_d = measured_now_i;
          end
          cap_active_d  = 1'b1;
          probe_count_d = '0;
          probe_ref_d   = measured_now_i;
        end

        if (cap_active_d && (cap_value_d != '0)) begin
          cap_plus      = SW'(cap_value_d) + SW'(cfg_i.recovery_margin);
          ref_plus      = SW'(probe_ref_d) + SW'(cfg_i.recovery_margin);
          probe_count_d = probe_count_d + TC'(1);
          if (probe_count_d >= sat_probe) begin
            probe_count_d = '0;
            if ((meas_w >= cap_plus) || (meas_w > ref_plus)) begin
              release_cap = 1'b1;
            end else begin
              probe_ref_d = measured_now_i;
            end
          end else if (meas_w >= cap_plus) begin
            release_cap = 1'b1;
          end

          if (release_cap) begin
            cap_active_d  = 1'b0;
            cap_value_d   = '0;
            probe_count_d = '0;
            probe_ref_d   = '0;
            holdoff_d     = '0;
          end else begin
            granted_limit_o = (limit_current_i < cap_value_d) ? limit_current_i
                                                              : cap_value_d;
            cap_applied_o   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_active_q  <= 1'b0;
      cap_value_q   <= '0;
      probe_count_q <= '0;
      probe_ref_q   <= '0;
      holdoff_q     <= '0;
      prev_chg_q    <= 1'b0;
      prev_offer_q  <= '0;
    end else if (step_en_i) begin
      cap_active_q  <= cap_active_d;
      cap_value_q   <= cap_value_d;
      probe_count_q <= probe_count_d;
      probe_ref_q   <= probe_ref_d;
      holdoff_q     <= holdoff_d;
      prev_chg_q    <= prev_chg_d;
      prev_offer_q  <= prev_offer_d;
    end
  end

  // A cap is only ever latched from a nonzero draw.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_active_q |-> (cap_value_q != '0))
    else $error("active cap holds a zero value");

  // Releasing the cap clears every piece of cap state together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cap_active_q |-> ((cap_value_q == '0) && (probe_count_q == '0) && (probe_ref_q == '0)))
    else $error("cap state left over after release");

  // A capped grant never exceeds the limit it was given.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_applied_o |-> (granted_limit_o <= limit_current_i))
    else $error("capped grant above limit");

  // Without a charging vehicle the grant passes through untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_charging_i |-> (!cap_applied_o && (granted_limit_o == limit_current_i)))
    else $error("cap applied while not charging");

endmodule

// File: rtl/core/charge_demand_cap_tracker_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_ready_o     limit, measured, pilot, offered, flags
// out      output     out_valid_o / out_ready_i   granted_limit_o, cap_applied_o
// cfg      input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One beat in gives one beat out. A beat is held in the input register, then
// the tracker logic runs combinationally into the result register, and the block
// takes one beat per cycle when out is not stalled.
// The tracker state advances when a beat moves from the input to the result register.
// Reset clears the tracker state and loads the register defaults; cfg_ready_o is high.
// When out stalls, the input register holds and in_ready_o drops once it is full.
module charge_demand_cap_tracker_core #(
  parameter int CURRENT_BITS    = 13,
  parameter int TICK_COUNT_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [CURRENT_BITS-1:0]          limit_current_i,
  input  logic [CURRENT_BITS-1:0]          measured_now_i,
  input  logic [CURRENT_BITS-1:0]          pilot_now_i,
  input  logic [CURRENT_BITS-1:0]          offered_now_i,
  input  logic                             is_charging_i,
  input  logic                             is_demanding_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [CURRENT_BITS-1:0]          granted_limit_o,
  output logic                             cap_applied_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cdct_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [cdct_pkg::CfgDataBits-1:0] cfg_data_i
);

  logic                    in_valid_q;
  logic [CURRENT_BITS-1:0] limit_q, meas_q, pilot_q, offer_q;
  logic                    charging_q, demanding_q;
  logic                    out_valid_q;
  logic [CURRENT_BITS-1:0] granted_q;
  logic                    cap_applied_q;

  logic                    advance, step_en, in_take;
  logic [CURRENT_BITS-1:0] min_charge;
  cdct_pkg::cfg_t          cfg;
  logic [CURRENT_BITS-1:0] granted_d;
  logic                    cap_applied_d;

  assign advance     = !out_valid_q || out_ready_i;
  assign step_en     = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  cdct_cfg_regs #(
    .CURRENT_BITS (CURRENT_BITS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .min_charge_o (min_charge),
    .cfg_o        (cfg)
  );

  cdct_tracker #(
    .CURRENT_BITS    (CURRENT_BITS),
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_en_i       (step_en),
    .min_charge_i    (min_charge),
    .cfg_i           (cfg),
    .limit_current_i (limit_q),
    .measured_now_i  (meas_q),
    .pilot_now_i     (pilot_q),
    .offered_now_i   (offer_q),
    .is_charging_i   (charging_q),
    .is_demanding_i  (demanding_q),
    .granted_limit_o (granted_d),
    .cap_applied_o   (cap_applied_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      limit_q     <= limit_current_i;
      meas_q      <= measured_now_i;
      pilot_q     <= pilot_now_i;
      offer_q     <= offered_now_i;
      charging_q  <= is_charging_i;
      demanding_q <= is_demanding_i;
    end
    if (step_en) begin
      granted_q     <= granted_d;
      cap_applied_q <= cap_applied_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_limit_o = granted_q;
  assign cap_applied_o   = cap_applied_q;

endmodule

// File: test/cap_tracker_grant_pkg.sv
`timescale 1ns / 1ps

package cap_tracker_grant_pkg;

  import cdct_pkg::*;

  localparam int CurBits  = 13;
  localparam int TickMask = 255;

  typedef logic [CurBits-1:0] current_t;

  typedef struct packed {
    current_t limit;
    current_t measured;
    current_t pilot;
    current_t offered;
    logic     charging;
    logic     demanding;
  } tick_t;

  typedef struct packed {
    current_t granted;
    logic     capped;
  } grant_t;

  // Tracks the cap state of the charger and the grants it must produce, in order.
  class grant_checker;
    int unsigned min_charge;
    int unsigned detect_marg;
    int unsigned recov_marg;
    int unsigned offer_step;
    int unsigned probe_intvl;
    int unsigned holdoff_len;

    bit          cap_active;
    int unsigned cap_value;
    int unsigned probe_count;
    int unsigned probe_ref;
    int unsigned holdoff_left;
    bit          prev_charging;
    int unsigned prev_offer;

    grant_t      pending_grants[$];
    int unsigned mismatches;

    function new();
      min_charge    = MinChargeReset;
      detect_marg   = DetectMargReset;
      recov_marg    = RecovMargReset;
      offer_step    = OfferStepReset;
      probe_intvl   = ProbeIntvlReset;
      holdoff_len   = HoldoffReset;
      prev_charging = 1'b0;
      prev_offer    = 0;
      mismatches    = 0;
      drop_cap();
    endfunction

    function void drop_cap();
      cap_active   = 1'b0;
      cap_value    = 0;
      probe_count  = 0;
      probe_ref    = 0;
      holdoff_left = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CfgDataBits-1:0] data);
      case (idx)
        CFG_MIN_CHARGE:  min_charge  = data[CurBits-1:0];
        CFG_DETECT_MARG: detect_marg = data[MarginBits-1:0];
        CFG_RECOV_MARG:  recov_marg  = data[MarginBits-1:0];
        CFG_OFFER_STEP:  offer_step  = data[MarginBits-1:0];
        CFG_PROBE_INTVL: probe_intvl = data[TickCfgBits-1:0];
        CFG_HOLDOFF:     holdoff_len = data[TickCfgBits-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_grants.size();
    endfunction

    function void predict_grant(tick_t t);
      grant_t      want;
      bit          allowed;
      bit          released;
      int unsigned meas;
      int unsigned pilot;
      int unsigned offer;
      meas         = t.measured;
      pilot        = t.pilot;
      offer        = t.offered;
      want.granted = t.limit;
      want.capped  = 1'b0;
      if (!t.demanding || t.limit == '0) begin
        drop_cap();
        prev_charging = 1'b0;
      end else begin
        if (t.charging != prev_charging) drop_cap();
        prev_charging = t.charging;
        if (!t.charging) begin
          prev_offer = 0;
        end else begin
          allowed = 1'b1;
          // A step up in the offer suppresses detection while the vehicle ramps.
          if (prev_offer > 0 && offer > prev_offer + offer_step) holdoff_left = holdoff_len;
          prev_offer = offer;
          if (holdoff_left > 0) begin
            holdoff_left--;
            allowed = 1'b0;
          end
          if (allowed && pilot > min_charge && meas > 0 && meas + detect_marg < pilot) begin
            if (!cap_active || meas < cap_value) cap_value = meas;
            cap_active  = 1'b1;
            probe_count = 0;
            probe_ref   = meas;
          end
          if (cap_active && cap_value > 0) begin
            probe_count = (probe_count + 1) & TickMask;
            if (probe_count >= probe_intvl) begin
              probe_count = 0;
              released = (meas >= cap_value + recov_marg) || (meas > probe_ref + recov_marg);
              if (!released) probe_ref = meas;
            end else begin
              released = (meas >= cap_value + recov_marg);
            end
            if (released) begin
              drop_cap();
            end else begin
              want.granted = (t.limit < cap_value) ? t.limit : current_t'(cap_value);
              want.capped  = 1'b1;
            end
          end
        end
      end
      pending_grants = {pending_grants, want};
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_grant(current_t granted, logic capped);
      grant_t want;
      if (pending_grants.size() == 0) begin
        note_failure($sformatf("granted_limit %0d cap_applied %0b with no tick pending",
                               granted, capped));
      end else begin
        want = pending_grants.pop_front();
        if (granted !== want.granted || capped !== want.capped)
          note_failure($sformatf(
              "granted_limit expected %0d got %0d, cap_applied expected %0b got %0b",
              want.granted, granted, want.capped, capped));
      end
    endfunction
  endclass

endpackage

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

  import cdct_pkg::*;
  import cap_tracker_grant_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  current_t               limit_current = '0;
  current_t               measured_now = '0;
  current_t               pilot_now = '0;
  current_t               offered_now = '0;
  logic                   is_charging = 1'b0;
  logic                   is_demanding = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  current_t               granted_limit;
  logic                   cap_applied;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_idx_e               cfg_index = CFG_MIN_CHARGE;
  logic [CfgDataBits-1:0] cfg_data = '0;

  grant_checker grants;
  int unsigned  burst_left = 0;

  charge_demand_cap_tracker_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .limit_current_i (limit_current),
    .measured_now_i  (measured_now),
    .pilot_now_i     (pilot_now),
    .offered_now_i   (offered_now),
    .is_charging_i   (is_charging),
    .is_demanding_i  (is_demanding),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .granted_limit_o (granted_limit),
    .cap_applied_o   (cap_applied),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // The receiver switches between free flow, random stalls, long stalls and toggling ready.
  initial begin
    int unsigned mode;
    int unsigned span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 40);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= 1'b0;
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) grants.check_grant(granted_limit, cap_applied);
  end

  function automatic tick_t mk_tick(int limit, int meas, int pilot, int offer,
                                    bit charging, bit demanding);
    tick_t t;
    t.limit     = current_t'(limit);
    t.measured  = current_t'(meas);
    t.pilot     = current_t'(pilot);
    t.offered   = current_t'(offer);
    t.charging  = charging;
    t.demanding = demanding;
    return t;
  endfunction

  function automatic int clamp_current(int v);
    return (v < 0) ? 0 : ((v > 8000) ? 8000 : v);
  endfunction

  // Random upper bits above the register width must be dropped by the block.
  function automatic logic [CfgDataBits-1:0] with_junk(int unsigned v, int unsigned width);
    int unsigned junk;
    junk = ($urandom_range(0, 1) != 0) ? ($urandom << width) : 0;
    return CfgDataBits'(v | junk);
  endfunction

  task automatic send_tick(input tick_t t);
    int unsigned gap;
    @(negedge clk);
    in_valid      <= 1'b1;
    limit_current <= t.limit;
    measured_now  <= t.measured;
    pilot_now     <= t.pilot;
    offered_now   <= t.offered;
    is_charging   <= t.charging;
    is_demanding  <= t.demanding;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    grants.predict_grant(t);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic pause_sender();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataBits-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    grants.write_register(idx, data);
  endtask

  task automatic apply_settings(input logic [CfgDataBits-1:0] min_charge, detect_marg,
                                recov_marg, offer_step, probe_intvl, holdoff_len);
    pause_sender();
    while (grants.pending() != 0) @(posedge clk);
    cfg_write(CFG_MIN_CHARGE, min_charge);
    cfg_write(CFG_DETECT_MARG, detect_marg);
    cfg_write(CFG_RECOV_MARG, recov_marg);
    cfg_write(CFG_OFFER_STEP, offer_step);
    cfg_write(CFG_PROBE_INTVL, probe_intvl);
    cfg_write(CFG_HOLDOFF, holdoff_len);
    // An index past the last register must change nothing.
    cfg_write(cfg_idx_e'(CFG_HOLDOFF + $urandom_range(1, 2)), CfgDataBits'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_random_settings();
    apply_settings(with_junk($urandom_range(0, 3000), CurBits),
                   with_junk($urandom_range(0, 200), MarginBits),
                   with_junk($urandom_range(0, 200), MarginBits),
                   with_junk($urandom_range(0, 400), MarginBits),
                   with_junk($urandom_range(0, 12), TickCfgBits),
                   with_junk($urandom_range(0, 10), TickCfgBits));
  endtask

  // Mostly charging sessions with a drifting draw, so that caps form, tighten and release;
  // a few stray ticks with every field random are mixed in.
  task automatic run_sessions(input int unsigned n_items);
    tick_t       t;
    int unsigned sent;
    int unsigned run_len;
    int          level;
    int          pilot;
    int          offer;
    int          limit;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        t = mk_tick($urandom_range(0, 8000), $urandom_range(0, 8000), $urandom_range(0, 8000),
                    $urandom_range(0, 8000), 1'($urandom), 1'($urandom));
        send_tick(t);
        sent++;
      end else begin
        run_len = $urandom_range(4, 40);
        pilot   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8000) : $urandom_range(600, 8000);
        offer   = $urandom_range(0, 8000);
        limit   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1500) : $urandom_range(1, 8000);
        level   = $urandom_range(0, pilot);
        for (int i = 0; i < run_len && sent < n_items; i++) begin
          case ($urandom_range(0, 15))
            0:       level = $urandom_range(0, pilot);
            1, 2:    level += int'($urandom_range(0, 60));
            3:       level = pilot;
            4:       level -= int'($urandom_range(0, 60));
            5:       pilot = $urandom_range(0, 8000);
            6:       offer += int'($urandom_range(0, 400));
            7:       offer = $urandom_range(0, 8000);
            default: level += int'($urandom_range(0, 10)) - 5;
          endcase
          level = clamp_current(level);
          offer = clamp_current(offer);
          t = mk_tick(($urandom_range(0, 39) == 0) ? 0 : limit, level, pilot, offer,
                      $urandom_range(0, 29) != 0, $urandom_range(0, 39) != 0);
          send_tick(t);
          sent++;
        end
      end
    end
  endtask

  initial begin
    grants = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks under the reset settings.
    send_tick(mk_tick(8000, 0, 0, 0, 1'b0, 1'b0));           // station idle
    send_tick(mk_tick(0, 8000, 8000, 8000, 1'b1, 1'b1));     // limit of zero disables
    send_tick(mk_tick(3200, 0, 3200, 3200, 1'b0, 1'b1));     // not charging
    send_tick(mk_tick(3200, 3200, 3200, 3000, 1'b1, 1'b1));  // first offer, no holdoff
    send_tick(mk_tick(3200, 1000, 3200, 3200, 1'b1, 1'b1));  // offer rise starts holdoff
    repeat (5) send_tick(mk_tick(3200, 1000, 3200, 3200, 1'b1, 1'b1));
    send_tick(mk_tick(3200, 1000, 3200, 3200, 1'b1, 1'b1));  // shortfall latched
    send_tick(mk_tick(3200, 800, 3200, 3200, 1'b1, 1'b1));   // lower draw tightens the cap
    repeat (4) send_tick(mk_tick(3200, 800, 500, 3200, 1'b1, 1'b1));
    send_tick(mk_tick(3200, 700, 500, 3200, 1'b1, 1'b1));    // probe holds, reference drops
    repeat (5) send_tick(mk_tick(3200, 790, 500, 3200, 1'b1, 1'b1));
    send_tick(mk_tick(3200, 790, 500, 3200, 1'b1, 1'b1));    // probe sees a rise and releases
    send_tick(mk_tick(500, 1000, 3200, 3200, 1'b1, 1'b1));   // limit below the cap
    send_tick(mk_tick(8000, 8000, 8000, 8000, 1'b0, 1'b1));  // charging stops
    run_sessions(50);

    apply_settings(0, 0, 0, 0, 0, 0);
    run_sessions(50);
    apply_settings(8000, 1000, 1000, 1000, 255, 255);
    run_sessions(40);
    apply_settings('1, '1, '1, '1, '1, '1);
    run_sessions(20);
    apply_settings(600, 25, 25, 50, 1, 1);
    run_sessions(50);
    repeat (2) begin
      apply_random_settings();
      run_sessions(50);
    end

    pause_sender();
    while (grants.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (grants.mismatches == 0 && grants.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: charge_demand_cap_tracker_core.f
rtl/core/cdct_pkg.sv
rtl/core/cdct_cfg_regs.sv
rtl/core/cdct_tracker.sv
rtl/core/charge_demand_cap_tracker_core.sv
test/cap_tracker_grant_pkg.sv
test/tb.sv
